>>> rtl/v44_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// v44_pkg
// Shared constants for the 4x4 matrix transform: register file layout,
// field widths and the identity matrix loaded at reset.
// ----------------------------------------------------------------------------
package v44_pkg;

  // Port field width of one vector or result element
  localparam int FIELD_W   = 32;
  // One matrix register holds two 32-bit element slots
  localparam int REG_W     = 64;
  localparam int SLOT_W    = 32;
  localparam int NUM_REGS  = 8;
  localparam int REG_SEL_W = 3;
  // Configuration index port width; indexes past the register file are dropped
  localparam int CFG_IDX_W = 8;
  localparam int VEC_LEN   = 4;

  typedef logic [NUM_REGS-1:0][REG_W-1:0] mat_regs_t;

  // Identity matrix in Q16.16, register 7 first
  localparam mat_regs_t MAT_RESET = {
    64'h0001_0000_0000_0000,  // row3_cols23
    64'h0000_0000_0000_0000,  // row3_cols01
    64'h0000_0000_0001_0000,  // row2_cols23
    64'h0000_0000_0000_0000,  // row2_cols01
    64'h0000_0000_0000_0000,  // row1_cols23
    64'h0001_0000_0000_0000,  // row1_cols01
    64'h0000_0000_0000_0000,  // row0_cols23
    64'h0000_0000_0001_0000   // row0_cols01
  };

endpackage

>>> rtl/v44_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// v44_cfg
// Matrix register file: eight 64-bit registers written one word at a time,
// reset to the identity matrix.
// ----------------------------------------------------------------------------
module v44_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [v44_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [v44_pkg::REG_W-1:0]     wr_data,
  output v44_pkg::mat_regs_t            mat
);
  import v44_pkg::*;

  logic in_range;

  // Drop writes past the last register
  assign in_range = (wr_index < CFG_IDX_W'(NUM_REGS));

  // Load one register per accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      mat <= MAT_RESET;
    end else if (wr_en && in_range) begin
      mat[wr_index[REG_SEL_W-1:0]] <= wr_data;
    end
  end

endmodule

>>> rtl/v44_dot.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// v44_dot
// One output column: four products, a two-level adder tree, then an
// arithmetic shift by the fraction width and saturation to one word.
// Four register stages; a valid bit travels alongside.
// ----------------------------------------------------------------------------
module v44_dot #(
  parameter int FRAC_BITS  = 16,
  parameter int WORD_WIDTH = 32
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   vld_in,
  input  logic [v44_pkg::VEC_LEN-1:0][WORD_WIDTH-1:0] vec,
  input  logic [v44_pkg::VEC_LEN-1:0][WORD_WIDTH-1:0] col,
  output logic                                   vld_out,
  output logic [WORD_WIDTH-1:0]                  res,
  output logic                                   ovf
);
  import v44_pkg::*;

  localparam int PW = 2 * WORD_WIDTH;  // one product
  localparam int AW = PW + 1;          // sum of two products
  localparam int SW = PW + 2;          // sum of four products
  localparam logic [WORD_WIDTH-1:0] MAXV = {1'b0, {(WORD_WIDTH-1){1'b1}}};
  localparam logic [WORD_WIDTH-1:0] MINV = {1'b1, {(WORD_WIDTH-1){1'b0}}};

  logic [VEC_LEN-1:0][PW-1:0] prod;
  logic [AW-1:0]              pair0, pair1;
  logic [SW-1:0]              sum;
  logic                       vld_a, vld_b, vld_c;

  logic signed [SW-1:0]       shifted;
  logic [SW-WORD_WIDTH:0]     top_bits;
  logic                       fits;
  logic [WORD_WIDTH-1:0]      res_next;

  // Stage A: multiply each element pair
  always_ff @(posedge clk) begin
    for (int i = 0; i < VEC_LEN; i++) begin
      prod[i] <= PW'($signed(vec[i])) * PW'($signed(col[i]));
    end
  end

  // Stage B: add products in pairs
  always_ff @(posedge clk) begin
    pair0 <= AW'($signed(prod[0])) + AW'($signed(prod[1]));
    pair1 <= AW'($signed(prod[2])) + AW'($signed(prod[3]));
  end

  // Stage C: full-width sum
  always_ff @(posedge clk) begin
    sum <= SW'($signed(pair0)) + SW'($signed(pair1));
  end

  // Shift back to the fraction position and saturate
  always_comb begin
    shifted  = $signed(sum) >>> FRAC_BITS;
    top_bits = shifted[SW-1:WORD_WIDTH-1];
    fits     = (&top_bits) || !(|top_bits);
    if (fits) begin
      res_next = shifted[WORD_WIDTH-1:0];
    end else if (sum[SW-1]) begin
      res_next = MINV;
    end else begin
      res_next = MAXV;
    end
  end

  // Stage D: result register
  always_ff @(posedge clk) begin
    res <= res_next;
    ovf <= !fits;
  end

  // Advance the valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a   <= 1'b0;
      vld_b   <= 1'b0;
      vld_c   <= 1'b0;
      vld_out <= 1'b0;
    end else begin
      vld_a   <= vld_in;
      vld_b   <= vld_a;
      vld_c   <= vld_b;
      vld_out <= vld_c;
    end
  end

`ifndef ASSERT_OFF
  // Every accepted word comes out on vld_out, through vld_a, vld_b and vld_c
  a_latency: assert property (@(posedge clk) disable iff (rst)
    vld_in |-> ##4 vld_out)
    else $error("v44_dot: accepted word did not emerge after four cycles");

  // No result appears without a matching accepted word
  a_no_ghost: assert property (@(posedge clk) disable iff (rst)
    vld_out |-> $past(vld_in, 4))
    else $error("v44_dot: result without a matching input word");

  // A saturated result is one of the two limits
  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    (vld_out && ovf) |-> (res == MAXV || res == MINV))
    else $error("v44_dot: overflow flagged with a value off the limits");
`endif

endmodule

>>> rtl/vec4_mat44_transform.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vec4_mat44_transform
// Row vector times 4x4 matrix in signed fixed point. Four column lanes each
// form a dot product, shift by FRAC_BITS and saturate to WORD_WIDTH bits.
// ----------------------------------------------------------------------------
// Pipeline: one multiplier stage, two adder stages and one shift and saturate
//   stage lie between the accepting edge and the done strobe.
// Throughput: one vector per cycle; busy stays low once out of reset.
// Reset: synchronous; loads the identity matrix, clears the pipeline valid
//   bits, and holds busy high as a registered copy of reset. Results cannot be stalled.
// ----------------------------------------------------------------------------
module vec4_mat44_transform #(
  parameter int FRAC_BITS  = 16,
  parameter int WORD_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [v44_pkg::FIELD_W-1:0] vec_x,
  input  logic signed [v44_pkg::FIELD_W-1:0] vec_y,
  input  logic signed [v44_pkg::FIELD_W-1:0] vec_z,
  input  logic signed [v44_pkg::FIELD_W-1:0] vec_w,
  output logic                          done,
  output logic signed [v44_pkg::FIELD_W-1:0] out_x,
  output logic signed [v44_pkg::FIELD_W-1:0] out_y,
  output logic signed [v44_pkg::FIELD_W-1:0] out_z,
  output logic signed [v44_pkg::FIELD_W-1:0] out_w,
  output logic                          overflow,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [v44_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [v44_pkg::REG_W-1:0]     cfg_data
);
  import v44_pkg::*;

  mat_regs_t                              mat;
  logic [VEC_LEN-1:0][WORD_WIDTH-1:0]     vec;
  logic [VEC_LEN-1:0][VEC_LEN-1:0][WORD_WIDTH-1:0] cols;
  logic [VEC_LEN-1:0]                     lane_vld;
  logic [VEC_LEN-1:0][WORD_WIDTH-1:0]     lane_res;
  logic [VEC_LEN-1:0]                     lane_ovf;
  logic                                   accept;

  // Busy is a registered copy of reset
  always_ff @(posedge clk) begin
    busy <= rst;
  end

  assign accept    = start && !busy;
  assign cfg_ready = !busy;

  v44_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .mat      (mat)
  );

  // Keep the low WORD_WIDTH bits of each input element
  assign vec[0] = vec_x[WORD_WIDTH-1:0];
  assign vec[1] = vec_y[WORD_WIDTH-1:0];
  assign vec[2] = vec_z[WORD_WIDTH-1:0];
  assign vec[3] = vec_w[WORD_WIDTH-1:0];

  // Gather matrix column c: element r sits in register 2r + c/2, slot c%2
  always_comb begin
    for (int c = 0; c < VEC_LEN; c++) begin
      for (int r = 0; r < VEC_LEN; r++) begin
        cols[c][r] = mat[2 * r + c / 2][SLOT_W * (c % 2) +: WORD_WIDTH];
      end
    end
  end

  // One lane per output column
  for (genvar c = 0; c < VEC_LEN; c++) begin : g_lane
    v44_dot #(
      .FRAC_BITS  (FRAC_BITS),
      .WORD_WIDTH (WORD_WIDTH)
    ) u_dot (
      .clk     (clk),
      .rst     (rst),
      .vld_in  (accept),
      .vec     (vec),
      .col     (cols[c]),
      .vld_out (lane_vld[c]),
      .res     (lane_res[c]),
      .ovf     (lane_ovf[c])
    );
  end

  // Sign-extend each lane result to the port width
  assign out_x    = FIELD_W'($signed(lane_res[0]));
  assign out_y    = FIELD_W'($signed(lane_res[1]));
  assign out_z    = FIELD_W'($signed(lane_res[2]));
  assign out_w    = FIELD_W'($signed(lane_res[3]));
  assign overflow = |lane_ovf;
  assign done     = lane_vld[0];

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for vec4_mat44_transform. It loads a series of
// matrices (identity, saturating extremes, random, small and mixed) and
// streams row vectors through each one. Every result word is checked
// against a bench-side fixed-point model of the dot products, the
// truncating shift and the saturation.
// ----------------------------------------------------------------------------
module tb_top;
  import v44_pkg::*;

  localparam int FRAC_BITS     = 16;
  localparam int WORD_WIDTH    = 32;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_VECS    = 250;
  localparam int NUM_PHASES    = 6;

  typedef logic signed [FIELD_W-1:0] word_t;
  typedef logic signed [2*WORD_WIDTH+3:0] acc_t;

  typedef struct {
    word_t x;
    word_t y;
    word_t z;
    word_t w;
    logic  ovf;
  } xform_row_t;

  typedef enum int {MODE_FULL, MODE_SMALL, MODE_MID, MODE_EDGE, MODE_MIXED} pick_mode_t;

  localparam word_t W_MAX = 32'sh7fff_ffff;
  localparam word_t W_MIN = 32'sh8000_0000;
  localparam word_t W_ONE = 32'sh0001_0000;

  // Matrix copy, transform model and queue of pending result words
  class mat_xform_board;
    word_t       coef[4][4];
    xform_row_t  expected_rows[$];
    int unsigned err_cnt;

    function new();
      for (int r = 0; r < 4; r++)
        for (int c = 0; c < 4; c++)
          coef[r][c] = (r == c) ? W_ONE : '0;
      err_cnt = 0;
    endfunction

    // Mirror a register write; indexes past the file are dropped
    function void load_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] data);
      int r;
      int c;
      if (idx < CFG_IDX_W'(NUM_REGS)) begin
        r = int'(idx[2:1]);
        c = 2 * int'(idx[0]);
        coef[r][c]     = data[SLOT_W-1:0];
        coef[r][c + 1] = data[REG_W-1:SLOT_W];
      end
    endfunction

    // Form the four saturated column dot products of an accepted vector
    function void note_vector(word_t x, word_t y, word_t z, word_t w);
      word_t      v[4];
      word_t      res[4];
      acc_t       sum;
      acc_t       lim_hi;
      acc_t       lim_lo;
      xform_row_t row;
      v[0] = x;
      v[1] = y;
      v[2] = z;
      v[3] = w;
      lim_hi = (acc_t'(1) <<< (WORD_WIDTH - 1)) - 1;
      lim_lo = -lim_hi - 1;
      row.ovf = 1'b0;
      for (int c = 0; c < 4; c++) begin
        sum = '0;
        for (int i = 0; i < 4; i++)
          sum += acc_t'(signed'(v[i][WORD_WIDTH-1:0])) *
                 acc_t'(signed'(coef[i][c][WORD_WIDTH-1:0]));
        // Arithmetic shift rounds toward minus infinity
        sum = sum >>> FRAC_BITS;
        if (sum > lim_hi) begin
          sum = lim_hi;
          row.ovf = 1'b1;
        end else if (sum < lim_lo) begin
          sum = lim_lo;
          row.ovf = 1'b1;
        end
        res[c] = sum[FIELD_W-1:0];
      end
      row.x = res[0];
      row.y = res[1];
      row.z = res[2];
      row.w = res[3];
      expected_rows.push_back(row);
    endfunction

    function void compare_field(string name, word_t exp_v, word_t got_v);
      if (exp_v !== got_v) begin
        $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, got_v);
        err_cnt++;
      end
    endfunction

    // Check one result word against the oldest pending expectation
    function void check_row(word_t x, word_t y, word_t z, word_t w, logic ovf);
      xform_row_t exp_row;
      if (expected_rows.size() == 0) begin
        $display("%0t: unexpected result word: actual %h %h %h %h overflow %b",
                 $time, x, y, z, w, ovf);
        err_cnt++;
        return;
      end
      exp_row = expected_rows.pop_front();
      compare_field("out_x", exp_row.x, x);
      compare_field("out_y", exp_row.y, y);
      compare_field("out_z", exp_row.z, z);
      compare_field("out_w", exp_row.w, w);
      if (exp_row.ovf !== ovf) begin
        $display("%0t: overflow mismatch: expected %b, actual %b", $time, exp_row.ovf, ovf);
        err_cnt++;
      end
    endfunction

    function int pending();
      return expected_rows.size();
    endfunction

    function void report_missing();
      if (expected_rows.size() != 0) begin
        $display("%0t: %0d result words never arrived: expected %h %h %h %h, actual none",
                 $time, expected_rows.size(), expected_rows[0].x, expected_rows[0].y,
                 expected_rows[0].z, expected_rows[0].w);
        err_cnt += expected_rows.size();
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 start;
  logic                 busy;
  word_t                vec_x;
  word_t                vec_y;
  word_t                vec_z;
  word_t                vec_w;
  logic                 done;
  word_t                out_x;
  word_t                out_y;
  word_t                out_z;
  word_t                out_w;
  logic                 overflow;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [REG_W-1:0]     cfg_data;

  mat_xform_board board = new();
  int             burst_left = 0;

  vec4_mat44_transform #(
    .FRAC_BITS (FRAC_BITS),
    .WORD_WIDTH(WORD_WIDTH)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .vec_x    (vec_x),
    .vec_y    (vec_y),
    .vec_z    (vec_z),
    .vec_w    (vec_w),
    .done     (done),
    .out_x    (out_x),
    .out_y    (out_y),
    .out_z    (out_z),
    .out_w    (out_w),
    .overflow (overflow),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watch handshakes and result strobes at each edge
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        board.note_vector(vec_x, vec_y, vec_z, vec_w);
      end
      if (cfg_valid && cfg_ready) begin
        board.load_reg(cfg_index, cfg_data);
      end
      if (done) begin
        board.check_row(out_x, out_y, out_z, out_w, overflow);
      end
    end
  end

  function automatic word_t pick_word(pick_mode_t mode);
    word_t pool[7];
    pool = '{W_MAX, W_MIN, 32'sd0, 32'sd1, -32'sd1, W_ONE, -W_ONE};
    case (mode)
      MODE_FULL:  return word_t'($urandom);
      // Within +-4.0
      MODE_SMALL: return word_t'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
      // Within +-256.0
      MODE_MID:   return word_t'($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
      MODE_EDGE:  return pool[$urandom_range(0, 6)];
      default:    return pick_word(pick_mode_t'($urandom_range(0, 3)));
    endcase
  endfunction

  // Present one register word and hold it until taken; caller lowers valid
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_uniform(input word_t e);
    for (int i = 0; i < NUM_REGS; i++)
      cfg_write(CFG_IDX_W'(i), {e, e});
    cfg_valid <= 1'b0;
  endtask

  // Load a random matrix, sometimes followed by a write to a missing index
  task automatic load_random(input pick_mode_t mode);
    for (int i = 0; i < NUM_REGS; i++)
      cfg_write(CFG_IDX_W'(i), {pick_word(mode), pick_word(mode)});
    if ($urandom_range(0, 1) == 1)
      cfg_write(CFG_IDX_W'($urandom_range(NUM_REGS, 255)), {$urandom, $urandom});
    cfg_valid <= 1'b0;
  endtask

  // Present one vector word and hold it until accepted; caller lowers start
  task automatic send_vec(input word_t x, input word_t y, input word_t z, input word_t w);
    start <= 1'b1;
    vec_x <= x;
    vec_y <= y;
    vec_z <= z;
    vec_w <= w;
    do @(posedge clk); while (busy);
  endtask

  // Drop start and wait until every pending result word has come back
  task automatic drain_results();
    start <= 1'b0;
    do @(negedge clk); while (board.pending() != 0);
    @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Insert a random gap between vectors: mostly none, a few long, rare full drains
  task automatic hold_off();
    int gap;
    int r;
    gap = 0;
    if ($urandom_range(0, 199) == 0) begin
      drain_results();
      return;
    end
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    if ($urandom_range(0, 63) == 0) begin
      burst_left = $urandom_range(20, 60);
      return;
    end
    r = $urandom_range(0, 99);
    if (r < 50)
      gap = 0;
    else if (r < 88)
      gap = $urandom_range(1, 3);
    else if (r < 97)
      gap = $urandom_range(4, 12);
    else
      gap = $urandom_range(20, 60);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    rst       <= 1'b1;
    start     <= 1'b0;
    vec_x     <= '0;
    vec_y     <= '0;
    vec_z     <= '0;
    vec_w     <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Identity matrix from reset passes vectors through unchanged
    send_vec(32'sd0, 32'sd0, 32'sd0, 32'sd0);
    send_vec(W_MAX, W_MIN, -32'sd1, 32'sd1);
    send_vec(pick_word(MODE_FULL), pick_word(MODE_FULL), pick_word(MODE_FULL),
             pick_word(MODE_FULL));
    drain_results();

    // Largest positive elements: both saturation directions and floor on negatives
    load_uniform(W_MAX);
    send_vec(W_MAX, W_MAX, W_MAX, W_MAX);
    send_vec(W_MIN, W_MIN, W_MIN, W_MIN);
    send_vec(32'sd1, 32'sd0, 32'sd0, 32'sd0);
    send_vec(-32'sd1, 32'sd0, 32'sd0, 32'sd0);
    drain_results();

    // Most negative elements
    load_uniform(W_MIN);
    send_vec(W_MIN, W_MIN, W_MIN, W_MIN);
    send_vec(W_MAX, W_MAX, W_MAX, W_MAX);
    send_vec(W_MIN, 32'sd0, 32'sd0, 32'sd0);
    drain_results();

    // One-LSB elements: tiny sums truncate toward minus infinity
    load_uniform(32'sd1);
    send_vec(-32'sd1, 32'sd0, 32'sd0, 32'sd0);
    send_vec(32'sd1, 32'sd1, 32'sd1, 32'sd1);
    send_vec(-32'sd1, -32'sd1, -32'sd1, -32'sd1);
    drain_results();

    // Writes past the register file must leave the matrix alone
    cfg_write(CFG_IDX_W'(NUM_REGS), {$urandom, $urandom});
    cfg_write(CFG_IDX_W'(255), {$urandom, $urandom});
    cfg_valid <= 1'b0;
    send_vec(pick_word(MODE_MID), pick_word(MODE_MID), pick_word(MODE_MID),
             pick_word(MODE_MID));
    drain_results();

    // Random streams, one matrix flavor per phase
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      load_random(pick_mode_t'(ph % 5));
      for (int n = 0; n < PHASE_VECS; n++) begin
        if (n > 0)
          hold_off();
        send_vec(pick_word(MODE_MIXED), pick_word(MODE_MIXED), pick_word(MODE_MIXED),
                 pick_word(MODE_MIXED));
      end
      drain_results();
    end

    board.report_missing();
    if (board.err_cnt == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

  // Watchdog well past the slowest legal run
  initial begin
    #20_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
